>>> design/bmpd_pkg.sv
// ---------------------------------------------------------------------------
// bmpd_pkg: shared types and constants of the bitmap pixel stream decoder
// Holds the parser phase encoding, result status codes, header byte
// positions and the result struct passed from the parser to the output stage.
// ---------------------------------------------------------------------------
package bmpd_pkg;

  // default image size limits
  localparam int MAX_WIDTH_DEF  = 4096;
  localparam int MAX_HEIGHT_DEF = 4096;

  // header field byte positions
  localparam logic [31:0] POS_SIG_B     = 32'd0;
  localparam logic [31:0] POS_SIG_M     = 32'd1;
  localparam logic [31:0] POS_OFFSET_LO = 32'd10;
  localparam logic [31:0] POS_OFFSET_HI = 32'd13;
  localparam logic [31:0] POS_WIDTH_LO  = 32'd18;
  localparam logic [31:0] POS_WIDTH_HI  = 32'd21;
  localparam logic [31:0] POS_HEIGHT_LO = 32'd22;
  localparam logic [31:0] POS_HEIGHT_HI = 32'd25;
  localparam logic [31:0] POS_DEPTH_LO  = 32'd28;
  localparam logic [31:0] POS_DEPTH_HI  = 32'd29;
  localparam logic [31:0] HDR_BYTES     = 32'd30;

  // signature and pixel format constants
  localparam logic [7:0]  SIG_B        = 8'h42;
  localparam logic [7:0]  SIG_M        = 8'h4D;
  localparam logic [15:0] DEPTH_24     = 16'd24;
  localparam logic [15:0] DEPTH_32     = 16'd32;
  localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;

  // parser phases
  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_SKIP   = 3'd1,
    PH_PIXELS = 3'd2,
    PH_PAD    = 3'd3,
    PH_DONE   = 3'd4,
    PH_ERROR  = 3'd5
  } phase_e;

  // result status codes
  typedef enum logic [2:0] {
    ST_PIXEL      = 3'd0,
    ST_BAD_SIG    = 3'd1,
    ST_BAD_DEPTH  = 3'd2,
    ST_BAD_OFFSET = 3'd3,
    ST_TOO_LARGE  = 3'd4
  } status_e;

  // one result from the parser
  typedef struct packed {
    logic        valid;
    status_e     status;
    logic [23:0] index;
    logic [31:0] value;
    logic        last;
  } result_t;

endpackage

>>> design/bmpd_parser.sv
// ---------------------------------------------------------------------------
// bmpd_parser: header parser and pixel assembler
// Keeps the parse state, updates it once per accepted byte and presents the
// result, if any, that the byte causes as a combinational result struct.
// ---------------------------------------------------------------------------
module bmpd_parser
  import bmpd_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] stream_byte_i,
  input  logic       first_byte_i,
  output result_t    result_o
);

  phase_e      phase_q, phase_d, cur_phase;
  logic [31:0] pos_q, pos_d, cur_pos;
  logic [31:0] offset_q, offset_d, cur_offset;
  logic [12:0] width_q, width_d, cur_width;
  logic [12:0] height_q, height_d, cur_height;
  logic        four_q, four_d, cur_four;
  logic [12:0] col_q, col_d, cur_col;
  logic [12:0] row_q, row_d, cur_row;
  logic [1:0]  chpos_q, chpos_d, cur_chpos;
  logic [23:0] gath_q, gath_d, cur_gath;
  logic [1:0]  pad_q, pad_d, cur_pad;
  logic [23:0] base_q, base_d, cur_base;
  logic [15:0] depth_q, depth_d, cur_depth;
  logic        ovf_q, ovf_d, cur_ovf;

  logic [1:0]  fld_k;
  logic [25:0] base_prod;
  logic [13:0] col_inc;
  logic [13:0] row_inc;
  logic [1:0]  last_ch;
  result_t     res;

  // full 26-bit product of (height-1)*width; its low 24 bits give the row base
  assign base_prod = {13'd0, cur_height - 13'd1} * {13'd0, cur_width};

  // byte index inside a 4-byte header field; the offset, width and height fields start at 2 mod 4
  assign fld_k = 2'(cur_pos[1:0] - 2'd2);

  assign col_inc = {1'b0, cur_col} + 14'd1;
  assign row_inc = {1'b0, cur_row} + 14'd1;
  assign last_ch = cur_four ? 2'd3 : 2'd2;

  // next state and result for one byte
  always_comb begin
    // a start mark restarts the parser on this very byte
    if (first_byte_i) begin
      cur_phase  = PH_HEADER;
      cur_pos    = '0;
      cur_offset = '0;
      cur_width  = '0;
      cur_height = '0;
      cur_four   = 1'b0;
      cur_col    = '0;
      cur_row    = '0;
      cur_chpos  = '0;
      cur_gath   = '0;
      cur_pad    = '0;
      cur_base   = '0;
      cur_depth  = '0;
      cur_ovf    = 1'b0;
    end else begin
      cur_phase  = phase_q;
      cur_pos    = pos_q;
      cur_offset = offset_q;
      cur_width  = width_q;
      cur_height = height_q;
      cur_four   = four_q;
      cur_col    = col_q;
      cur_row    = row_q;
      cur_chpos  = chpos_q;
      cur_gath   = gath_q;
      cur_pad    = pad_q;
      cur_base   = base_q;
      cur_depth  = depth_q;
      cur_ovf    = ovf_q;
    end

    phase_d  = cur_phase;
    pos_d    = cur_pos;
    offset_d = cur_offset;
    width_d  = cur_width;
    height_d = cur_height;
    four_d   = cur_four;
    col_d    = cur_col;
    row_d    = cur_row;
    chpos_d  = cur_chpos;
    gath_d   = cur_gath;
    pad_d    = cur_pad;
    base_d   = cur_base;
    depth_d  = cur_depth;
    ovf_d    = cur_ovf;

    res        = '0;
    res.status = ST_PIXEL;

    case (cur_phase)
      PH_HEADER: begin
        if ((cur_pos == POS_SIG_B && stream_byte_i != SIG_B) ||
            (cur_pos == POS_SIG_M && stream_byte_i != SIG_M)) begin
          phase_d    = PH_ERROR;
          res.valid  = 1'b1;
          res.status = ST_BAD_SIG;
        end else begin
          // collect header fields
          if (cur_pos >= POS_OFFSET_LO && cur_pos <= POS_OFFSET_HI) begin
            offset_d = cur_offset | (32'(stream_byte_i) << {fld_k, 3'b000});
          end else if (cur_pos >= POS_WIDTH_LO && cur_pos <= POS_WIDTH_HI) begin
            case (fld_k)
              2'd0: width_d = {cur_width[12:8], stream_byte_i};
              2'd1: begin
                width_d = {stream_byte_i[4:0], cur_width[7:0]};
                if (stream_byte_i[7:5] != 3'd0) ovf_d = 1'b1;
              end
              default: if (stream_byte_i != 8'd0) ovf_d = 1'b1;
            endcase
          end else if (cur_pos >= POS_HEIGHT_LO && cur_pos <= POS_HEIGHT_HI) begin
            case (fld_k)
              2'd0: height_d = {cur_height[12:8], stream_byte_i};
              2'd1: begin
                height_d = {stream_byte_i[4:0], cur_height[7:0]};
                if (stream_byte_i[7:5] != 3'd0) ovf_d = 1'b1;
              end
              default: if (stream_byte_i != 8'd0) ovf_d = 1'b1;
            endcase
          end else if (cur_pos == POS_DEPTH_LO) begin
            depth_d = {cur_depth[15:8], stream_byte_i};
          end else if (cur_pos == POS_DEPTH_HI) begin
            depth_d = {stream_byte_i, cur_depth[7:0]};
          end

          pos_d = cur_pos + 32'd1;

          // header checks on the last header byte
          if (cur_pos == POS_DEPTH_HI) begin
            if (depth_d != DEPTH_24 && depth_d != DEPTH_32) begin
              phase_d    = PH_ERROR;
              res.valid  = 1'b1;
              res.status = ST_BAD_DEPTH;
            end else if (cur_offset < HDR_BYTES) begin
              phase_d    = PH_ERROR;
              res.valid  = 1'b1;
              res.status = ST_BAD_OFFSET;
            end else if (cur_ovf || cur_width > 13'(MAX_WIDTH) ||
                         cur_height > 13'(MAX_HEIGHT)) begin
              phase_d    = PH_ERROR;
              res.valid  = 1'b1;
              res.status = ST_TOO_LARGE;
            end else begin
              four_d  = (depth_d == DEPTH_32);
              col_d   = '0;
              row_d   = '0;
              chpos_d = '0;
              gath_d  = '0;
              pad_d   = '0;
              if (cur_width == 13'd0 || cur_height == 13'd0) begin
                phase_d = PH_DONE;
              end else begin
                base_d  = base_prod[23:0];
                phase_d = (pos_d == cur_offset) ? PH_PIXELS : PH_SKIP;
              end
            end
          end
        end
      end

      PH_SKIP: begin
        pos_d = cur_pos + 32'd1;
        if (pos_d == cur_offset) phase_d = PH_PIXELS;
      end

      PH_PIXELS: begin
        if (cur_chpos < last_ch) begin
          // gather blue, green and, for 32-bit pixels, red
          case (cur_chpos)
            2'd0:    gath_d = {cur_gath[23:8], cur_gath[7:0] | stream_byte_i};
            2'd1:    gath_d = {cur_gath[23:16], cur_gath[15:8] | stream_byte_i,
                               cur_gath[7:0]};
            default: gath_d = {cur_gath[23:16] | stream_byte_i, cur_gath[15:0]};
          endcase
          chpos_d = cur_chpos + 2'd1;
        end else begin
          // final byte of a pixel
          res.valid = 1'b1;
          if (cur_four) begin
            res.value = {stream_byte_i, cur_gath};
          end else begin
            res.value = {ALPHA_OPAQUE, cur_gath[23:16] | stream_byte_i, cur_gath[15:0]};
          end
          res.index = cur_base + {11'd0, cur_col};
          chpos_d   = '0;
          gath_d    = '0;
          if (col_inc < {1'b0, cur_width}) begin
            col_d = col_inc[12:0];
          end else begin
            col_d = '0;
            if (row_inc >= {1'b0, cur_height}) begin
              res.last = 1'b1;
              phase_d  = PH_DONE;
            end else begin
              row_d  = row_inc[12:0];
              base_d = cur_base - {11'd0, cur_width};
              pad_d  = cur_four ? 2'd0 : cur_width[1:0];
              if (pad_d != 2'd0) phase_d = PH_PAD;
            end
          end
        end
      end

      PH_PAD: begin
        pad_d = cur_pad - 2'd1;
        if (pad_d == 2'd0) phase_d = PH_PIXELS;
      end

      default: begin
      end
    endcase
  end

  assign result_o = res;

  // parse state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HEADER;
      pos_q    <= '0;
      offset_q <= '0;
      width_q  <= '0;
      height_q <= '0;
      four_q   <= 1'b0;
      col_q    <= '0;
      row_q    <= '0;
      chpos_q  <= '0;
      gath_q   <= '0;
      pad_q    <= '0;
      base_q   <= '0;
      depth_q  <= '0;
      ovf_q    <= 1'b0;
    end else if (accept_i) begin
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      offset_q <= offset_d;
      width_q  <= width_d;
      height_q <= height_d;
      four_q   <= four_d;
      col_q    <= col_d;
      row_q    <= row_d;
      chpos_q  <= chpos_d;
      gath_q   <= gath_d;
      pad_q    <= pad_d;
      base_q   <= base_d;
      depth_q  <= depth_d;
      ovf_q    <= ovf_d;
    end
  end

  // pixels come only out of the pixel phase
  a_pixel_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && res.valid && res.status == ST_PIXEL) |-> cur_phase == PH_PIXELS)
    else $error("pixel result outside pixel phase");

  // an error result parks the parser
  a_error_parks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && res.valid && res.status != ST_PIXEL) |=> phase_q == PH_ERROR)
    else $error("error result did not park the parser");

  // a fourth channel byte exists only for 32-bit pixels
  a_chpos_alpha: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (chpos_q == 2'd3) |-> four_q)
    else $error("alpha channel position in a 24-bit image");

endmodule

>>> design/bmp_pixel_stream_decoder_core.sv
// ---------------------------------------------------------------------------
// bmp_pixel_stream_decoder_core: uncompressed 24/32-bit bitmap decoder
// Parses a bitmap file one byte per cycle unless stalled; emits packed pixels
// with top-down destination index, or a single error status per bad file.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel: stream_byte_i with first_byte_i marking byte 0 of a new
//   file, moved under in_valid_i / in_stall_o. A request is taken at an edge
//   with in_valid_i high and in_stall_o low.
//   Output channel: status_o, pixel_index_o, pixel_value_o, last_pixel_o
//   under out_valid_o / out_stall_i. Skip and pad bytes, header bytes that
//   reveal no error, and every byte after an error or after the last pixel
//   give no output request; a result is registered as its byte is taken.
//   Throughput: one byte per cycle when not stalled; the parse state is updated
//   by a single pass of logic per byte, with one 13x13 multiply for the first
//   row base. When the receiver stalls, a result waits in the output register
//   and one more result can be held in a skid register; in_stall_o rises only
//   while the skid register is full, so header bytes keep flowing meanwhile.
//   Reset: the parser sits in the header phase at byte 0 and both output
//   registers are empty; no clearing pass is needed.
// ---------------------------------------------------------------------------
module bmp_pixel_stream_decoder_core
  import bmpd_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  stream_byte_i,
  input  logic        first_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [23:0] pixel_index_o,
  output logic [31:0] pixel_value_o,
  output logic        last_pixel_o
);

  logic    in_accept;
  logic    out_free;
  logic    new_res;
  result_t res;
  result_t out_q;
  result_t skid_q;
  logic    out_valid_q;
  logic    skid_valid_q;

  assign in_stall_o = skid_valid_q;
  assign in_accept  = in_valid_i && !skid_valid_q;

  // parser
  bmpd_parser #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (in_accept),
    .stream_byte_i (stream_byte_i),
    .first_byte_i  (first_byte_i),
    .result_o      (res)
  );

  assign new_res  = in_accept && res.valid;
  assign out_free = !out_valid_q || !out_stall_i;

  // output register and skid control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= new_res;
      end else begin
        out_valid_q  <= new_res;
      end
    end else if (new_res) begin
      skid_valid_q <= 1'b1;
    end
  end

  // output and skid payload
  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
        if (new_res) skid_q <= res;
      end else if (new_res) begin
        out_q <= res;
      end
    end else if (new_res) begin
      skid_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_q.status;
  assign pixel_index_o = out_q.index;
  assign pixel_value_o = out_q.value;
  assign last_pixel_o  = out_q.last;

  // the skid register holds data only behind a full output register
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register full with empty output register");

  // the skid register fills only while the output is stalled
  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!skid_valid_q && new_res && out_valid_q && out_stall_i) |=> skid_valid_q)
    else $error("stalled result not caught by skid register");

  // a stalled output request holds still
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> (out_valid_q && $stable(out_q)))
    else $error("stalled output request changed");

endmodule
